>>> rtl/ureg_pkg.sv
// Shared types, register offsets and control bit positions for the UART register block.
package ureg_pkg;

	// Transaction kind carried on the input tuser.
	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_RX    = 2'd2
	} kind_t;

	// Register offsets, new map and legacy map.
	localparam logic [3:0] ADDR_STATUS     = 4'd0;
	localparam logic [3:0] ADDR_CTRL_B     = 4'd1;
	localparam logic [3:0] ADDR_CTRL_C     = 4'd2;
	localparam logic [3:0] ADDR_BAUD       = 4'd4;
	localparam logic [3:0] ADDR_ZERO       = 4'd5;
	localparam logic [3:0] ADDR_DATA       = 4'd6;
	localparam logic [3:0] ADDR_OLD_BAUD   = 4'd9;
	localparam logic [3:0] ADDR_OLD_CTRL_B = 4'd10;
	localparam logic [3:0] ADDR_OLD_STATUS = 4'd11;
	localparam logic [3:0] ADDR_OLD_DATA   = 4'd12;
	localparam logic [3:0] ADDR_OLD_CTRL_C = 4'd13;

	// Control B interrupt enables and status bits.
	localparam int unsigned BIT_RX_IRQ    = 7;
	localparam int unsigned BIT_TX_IRQ    = 6;
	localparam int unsigned BIT_EMPTY_IRQ = 5;
	localparam logic [7:0] STATUS_BASE    = 8'h60;
	localparam logic [7:0] STATUS_FULL    = 8'h80;

	localparam int unsigned TDATA_W = 24;
	localparam int unsigned TUSER_W = 2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic [7:0] write_value;
		logic [3:0] reg_address;
		logic [1:0] kind;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_taken;
		logic       irq_receive;
		logic       irq_transmit;
		logic       irq_data_empty;
	} result_t;

endpackage

>>> rtl/ureg_core.sv
// Register file, receive holder and per-transaction decode of the UART register block.
module ureg_core
	import ureg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	output result_t result
);

	logic [7:0] baud_q, ctrl_b_q, ctrl_c_q, holder_byte_q;
	logic       holder_full_q;

	logic [7:0] baud_d, ctrl_b_d, ctrl_c_d, holder_byte_d;
	logic       holder_full_d;
	logic [7:0] status;

	assign status = STATUS_BASE | (holder_full_q ? STATUS_FULL : 8'h00);

	always_comb begin
		baud_d        = baud_q;
		ctrl_b_d      = ctrl_b_q;
		ctrl_c_d      = ctrl_c_q;
		holder_byte_d = holder_byte_q;
		holder_full_d = holder_full_q;
		result        = '0;
		unique case (kind_t'(item.kind))
			KIND_READ: begin
				unique case (item.reg_address)
					ADDR_STATUS, ADDR_OLD_STATUS: result.read_data = status;
					ADDR_CTRL_B, ADDR_OLD_CTRL_B: result.read_data = ctrl_b_q;
					ADDR_CTRL_C, ADDR_OLD_CTRL_C: result.read_data = ctrl_c_q;
					ADDR_BAUD, ADDR_OLD_BAUD:     result.read_data = baud_q;
					ADDR_DATA, ADDR_OLD_DATA: begin
						// Take the held byte; an empty holder reads zero.
						if (holder_full_q) begin
							result.read_data = holder_byte_q;
							holder_full_d    = 1'b0;
						end
					end
					default: result.read_data = 8'h00;
				endcase
			end
			KIND_WRITE: begin
				unique case (item.reg_address)
					ADDR_CTRL_B, ADDR_OLD_CTRL_B: begin
						ctrl_b_d              = item.write_value;
						result.irq_data_empty = item.write_value[BIT_EMPTY_IRQ];
					end
					ADDR_CTRL_C, ADDR_OLD_CTRL_C: ctrl_c_d = item.write_value;
					ADDR_BAUD, ADDR_OLD_BAUD:     baud_d   = item.write_value;
					ADDR_DATA, ADDR_OLD_DATA: begin
						result.tx_valid       = 1'b1;
						result.tx_byte        = item.write_value;
						result.irq_transmit   = ctrl_b_q[BIT_TX_IRQ];
						result.irq_data_empty = ctrl_b_q[BIT_EMPTY_IRQ];
					end
					default: ;
				endcase
			end
			KIND_RX: begin
				// Accept only into an empty holder; drop otherwise.
				if (item.rx_valid && !holder_full_q) begin
					holder_byte_d      = item.rx_byte;
					holder_full_d      = 1'b1;
					result.rx_taken    = 1'b1;
					result.irq_receive = ctrl_b_q[BIT_RX_IRQ];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_q        <= '0;
			ctrl_b_q      <= '0;
			ctrl_c_q      <= '0;
			holder_byte_q <= '0;
			holder_full_q <= 1'b0;
		end else if (en) begin
			baud_q        <= baud_d;
			ctrl_b_q      <= ctrl_b_d;
			ctrl_c_q      <= ctrl_c_d;
			holder_byte_q <= holder_byte_d;
			holder_full_q <= holder_full_d;
		end
	end

endmodule

>>> rtl/uart_register_block.sv
// Top level of the UART register block: input register, decode core and result register.
// Input register, then result register; the decode core is a single combinational pass.
// Throughput: one transaction per cycle while the result register is empty or drained.
// The input stays ready while a finished result waits, as long as the input register is free.
// Reset (arst_n low, asynchronous) empties both pipeline stages, clears baud, control B,
// control C and the receive holder (empty, byte zero).
module uart_register_block
	import ureg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Request stream
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// tdata, low bit up: reg_address[3:0], write_value[11:4], rx_valid[12],
	// rx_byte[20:13], zero pad[23:21]
	input  logic [TDATA_W-1:0] s_axis_tdata,
	// tuser: kind[1:0] (0 read, 1 write, 2 receive offer)
	input  logic [TUSER_W-1:0] s_axis_tuser,
	// Result stream
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// tdata, low bit up: read_data[7:0], tx_valid[8], tx_byte[16:9], rx_taken[17],
	// irq_receive[18], irq_transmit[19], irq_data_empty[20], zero pad[23:21]
	output logic [TDATA_W-1:0] m_axis_tdata
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_q;
	result_t result_q;
	result_t result;
	logic    advance;

	// Move the stage-1 transaction into the result register when that register is
	// empty or being drained this cycle; the register state updates on the same edge.
	assign advance       = valid_s1 && (!valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind        <= s_axis_tuser;
			item_s1.reg_address <= s_axis_tdata[3:0];
			item_s1.write_value <= s_axis_tdata[11:4];
			item_s1.rx_valid    <= s_axis_tdata[12];
			item_s1.rx_byte     <= s_axis_tdata[20:13];
		end
	end

	// Decode and state update; state commits only when the transaction advances.
	ureg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (result)
	);

	// Result register: hold until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {3'b000,
		result_q.irq_data_empty,
		result_q.irq_transmit,
		result_q.irq_receive,
		result_q.rx_taken,
		result_q.tx_byte,
		result_q.tx_valid,
		result_q.read_data};

endmodule

>>> test/tb_uart_register_block.sv
// Testbench for uart_register_block: random and directed traffic against a predictor.
`timescale 1ns / 100ps

module tb_uart_register_block
	import ureg_pkg::*;
();

	// Kind value with no meaning; the block must answer with an all-zero result.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int CLK_HALF     = 5;
	localparam int HOLD_CYCLES  = 300;     // long receiver hold-off for the backpressure test
	localparam int DRAIN_CYCLES = 10;      // margin after the drain for anything stray; kept generous
	localparam int LIMIT_CYCLES = 200000;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata  = '0;
	logic [TUSER_W-1:0] s_axis_tuser  = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;

	// Shadow copy of the block state, advanced once per accepted request.
	logic [7:0] shadow_baud   = '0;
	logic [7:0] shadow_ctrl_b = '0;
	logic [7:0] shadow_ctrl_c = '0;
	logic       shadow_full   = 1'b0;
	logic [7:0] shadow_byte   = '0;

	// Results predicted for accepted requests, oldest first.
	result_t pending_results [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int failures      = 0;
	int cycle_count   = 0;

	// Named offsets of either map (ADDR_ZERO reads zero); random accesses favor these.
	logic [3:0] mapped_addrs [0:10] = '{ADDR_STATUS, ADDR_CTRL_B, ADDR_CTRL_C, ADDR_BAUD,
		ADDR_ZERO, ADDR_DATA, ADDR_OLD_BAUD, ADDR_OLD_CTRL_B, ADDR_OLD_STATUS,
		ADDR_OLD_DATA, ADDR_OLD_CTRL_C};

	uart_register_block i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		// tdata, low bit up: reg_address, write_value, rx_valid, rx_byte, zero pad
		.s_axis_tdata  (s_axis_tdata),
		// tuser: kind
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// tdata, low bit up: read_data, tx_valid, tx_byte, rx_taken, irq_receive,
		// irq_transmit, irq_data_empty, zero pad
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	// Predict the result of one request and advance the shadow state.
	function automatic result_t predict_uart_result(input logic [1:0] kind,
		input logic [3:0] addr, input logic [7:0] wval, input logic rvalid,
		input logic [7:0] rbyte);
		result_t res;
		res = '0;
		case (kind)
			KIND_READ: begin
				case (addr)
					ADDR_STATUS, ADDR_OLD_STATUS:
						res.read_data = STATUS_BASE | (shadow_full ? STATUS_FULL : 8'h00);
					ADDR_CTRL_B, ADDR_OLD_CTRL_B: res.read_data = shadow_ctrl_b;
					ADDR_CTRL_C, ADDR_OLD_CTRL_C: res.read_data = shadow_ctrl_c;
					ADDR_BAUD, ADDR_OLD_BAUD:     res.read_data = shadow_baud;
					ADDR_DATA, ADDR_OLD_DATA: begin
						// Reading data takes the held byte; an empty holder reads zero.
						if (shadow_full) begin
							res.read_data = shadow_byte;
							shadow_full   = 1'b0;
						end
					end
					default: res.read_data = 8'h00;
				endcase
			end
			KIND_WRITE: begin
				case (addr)
					ADDR_CTRL_B, ADDR_OLD_CTRL_B: begin
						shadow_ctrl_b      = wval;
						res.irq_data_empty = wval[BIT_EMPTY_IRQ];
					end
					ADDR_CTRL_C, ADDR_OLD_CTRL_C: shadow_ctrl_c = wval;
					ADDR_BAUD, ADDR_OLD_BAUD:     shadow_baud   = wval;
					ADDR_DATA, ADDR_OLD_DATA: begin
						res.tx_valid       = 1'b1;
						res.tx_byte        = wval;
						res.irq_transmit   = shadow_ctrl_b[BIT_TX_IRQ];
						res.irq_data_empty = shadow_ctrl_b[BIT_EMPTY_IRQ];
					end
					default: ;
				endcase
			end
			KIND_RX: begin
				// A byte enters only an empty holder; otherwise it is dropped.
				if (rvalid && !shadow_full) begin
					shadow_byte     = rbyte;
					shadow_full     = 1'b1;
					res.rx_taken    = 1'b1;
					res.irq_receive = shadow_ctrl_b[BIT_RX_IRQ];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Offer one request from the falling edge on, with random idle cycles before it, and
	// return at the rising edge that accepts it. Valid stays high so that a following
	// request can follow back to back.
	task automatic send_item(input logic [1:0] kind, input logic [3:0] addr,
		input logic [7:0] wval, input logic rvalid, input logic [7:0] rbyte);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {3'b000, rbyte, rvalid, wval, addr};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(predict_uart_result(kind, addr, wval, rvalid, rbyte));
	endtask

	// Drop valid before any wait that does not go through send_item.
	task automatic idle_sender();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			failures++;
		end
	endtask

	// Receiver: random ready, or a long hold-off when a test asks for one.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served   <= hold_requests;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with none pending: tdata %h", m_axis_tdata);
				failures++;
			end else begin
				check_field("read_data", pending_results[0].read_data, m_axis_tdata[7:0]);
				check_field("tx_valid", pending_results[0].tx_valid, m_axis_tdata[8]);
				check_field("tx_byte", pending_results[0].tx_byte, m_axis_tdata[16:9]);
				check_field("rx_taken", pending_results[0].rx_taken, m_axis_tdata[17]);
				check_field("irq_receive", pending_results[0].irq_receive, m_axis_tdata[18]);
				check_field("irq_transmit", pending_results[0].irq_transmit,
					m_axis_tdata[19]);
				check_field("irq_data_empty", pending_results[0].irq_data_empty,
					m_axis_tdata[20]);
				void'(pending_results.pop_front());
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Both maps, register extremes, unmapped offsets and writes to read-only offsets.
	task automatic test_register_map();
		send_item(KIND_READ, ADDR_STATUS, 8'h00, 1'b0, 8'h00);
		send_item(KIND_WRITE, ADDR_CTRL_B, 8'hFF, 1'b0, 8'h00);    // bit 5 set: empty irq
		send_item(KIND_READ, ADDR_OLD_CTRL_B, 8'h00, 1'b0, 8'h00);
		send_item(KIND_WRITE, ADDR_CTRL_C, 8'hFF, 1'b1, 8'hFF);
		send_item(KIND_READ, ADDR_OLD_CTRL_C, 8'h00, 1'b0, 8'h00);
		send_item(KIND_WRITE, ADDR_OLD_BAUD, 8'h5A, 1'b0, 8'h00);
		send_item(KIND_READ, ADDR_BAUD, 8'h00, 1'b0, 8'h00);
		send_item(KIND_WRITE, ADDR_ZERO, 8'hFF, 1'b0, 8'h00);
		send_item(KIND_READ, ADDR_ZERO, 8'h00, 1'b0, 8'h00);
		send_item(KIND_WRITE, ADDR_STATUS, 8'hFF, 1'b0, 8'h00);    // read-only, ignored
		send_item(KIND_READ, 4'hF, 8'hFF, 1'b1, 8'hFF);            // unmapped, reads zero
		idle_sender();
	endtask

	// Data writes with the transmit and empty enables both set, transmit only, and neither.
	task automatic test_transmit();
		send_item(KIND_WRITE, ADDR_DATA, 8'hA5, 1'b0, 8'h00);
		send_item(KIND_WRITE, ADDR_OLD_CTRL_B, 8'hDF, 1'b0, 8'h00);
		send_item(KIND_WRITE, ADDR_OLD_DATA, 8'h00, 1'b0, 8'h00);
		send_item(KIND_WRITE, ADDR_CTRL_B, 8'h00, 1'b0, 8'h00);
		send_item(KIND_WRITE, ADDR_DATA, 8'hFF, 1'b0, 8'h00);
		idle_sender();
	endtask

	// Empty read, fill, drop while full, status full bit, take, receive irq.
	task automatic test_receive_holder();
		send_item(KIND_READ, ADDR_DATA, 8'h00, 1'b0, 8'h00);
		send_item(KIND_RX, 4'h0, 8'h00, 1'b1, 8'hFF);
		send_item(KIND_RX, 4'h0, 8'h00, 1'b1, 8'h00);              // holder full: dropped
		send_item(KIND_READ, ADDR_OLD_STATUS, 8'h00, 1'b0, 8'h00);
		send_item(KIND_READ, ADDR_OLD_DATA, 8'h00, 1'b0, 8'h00);
		send_item(KIND_WRITE, ADDR_CTRL_B, 8'h80, 1'b0, 8'h00);
		send_item(KIND_RX, 4'hF, 8'hFF, 1'b1, 8'h00);
		send_item(KIND_READ, ADDR_DATA, 8'h00, 1'b0, 8'h00);
		idle_sender();
	endtask

	// Unused kind and a receive offer without a byte both give an all-zero result.
	task automatic test_ignored_items();
		send_item(KIND_UNUSED, 4'hF, 8'hFF, 1'b1, 8'hFF);
		send_item(KIND_RX, 4'hF, 8'hFF, 1'b0, 8'hFF);
		idle_sender();
	endtask

	// Hold the result side off for a long stretch while requests keep coming, so the
	// pipeline fills and the input stalls.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_requests++;
		for (int i = 0; i < 30; i++)
			send_item(i[0] ? KIND_READ : KIND_RX, mapped_addrs[$urandom_range(10)],
				8'($urandom), 1'b1, 8'($urandom));
		idle_sender();
	endtask

	// Random traffic, mostly mapped accesses and valid receive offers.
	task automatic test_random(input int n_items, input int send_pct, input int recv_pct);
		int         counted;
		int         pick;
		logic [1:0] kind;
		logic [3:0] addr;
		logic [7:0] wval;
		logic       rvalid;
		logic [7:0] rbyte;
		counted       = 0;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (counted < n_items) begin
			pick = $urandom_range(99);
			if (pick < 40)
				kind = KIND_READ;
			else if (pick < 75)
				kind = KIND_WRITE;
			else if (pick < 97)
				kind = KIND_RX;
			else
				kind = KIND_UNUSED;
			addr   = ($urandom_range(3) != 0) ? mapped_addrs[$urandom_range(10)]
				: 4'($urandom_range(15));
			wval   = 8'($urandom);
			rvalid = ($urandom_range(7) != 0);
			rbyte  = 8'($urandom);
			send_item(kind, addr, wval, rvalid, rbyte);
			counted++;
		end
		idle_sender();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_register_map();
		test_transmit();
		test_receive_holder();
		test_ignored_items();
		test_backpressure();
		test_random(420, 26, 86);
		test_random(420, 86, 26);
		test_random(420, 0, 0);

		// Drain outstanding results, then wait out the drain margin for anything stray.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
rtl/ureg_pkg.sv
rtl/ureg_core.sv
rtl/uart_register_block.sv
test/tb_uart_register_block.sv
